// ----- hw/rtl/pbrc_pkg.sv -----
// Package of the paced bandwidth release curve block.
// Holds codes, item and handshake structs, and state types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pbrc_pkg;

   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_QUERY  = 2'd1;
   localparam logic [1:0] KIND_CHARGE = 2'd2;

   localparam logic [1:0] PRI_LOW    = 2'd0;
   localparam logic [1:0] PRI_NORMAL = 2'd1;
   localparam logic [1:0] PRI_HIGH   = 2'd2;

   localparam logic [1:0] MODE_BALANCED   = 2'd0;
   localparam logic [1:0] MODE_RELAXED    = 2'd1;
   localparam logic [1:0] MODE_AGGRESSIVE = 2'd2;

   localparam logic [1:0] CSR_CURVE_MODE = 2'd0;
   localparam logic [1:0] CSR_EXEC_INC   = 2'd1;
   localparam logic [1:0] CSR_RELEASE_Q  = 2'd2;

   localparam logic [31:0] EXEC_INC_RESET  = 32'd16384;
   localparam logic [31:0] RELEASE_Q_RESET = 32'd16384;

   typedef enum logic [1:0] {
      OP_START,
      OP_QUERY,
      OP_CHARGE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [47:0] time_msec;
      logic [31:0] span_ms;
      logic [31:0] up_quota;
      logic [31:0] down_quota;
      logic        direction;
      logic [1:0]  priority_req;
      logic        applies;
      logic [31:0] byte_count;
   } item_type;

   typedef struct packed {
      logic        start;
      logic [31:0] t;
      logic        which;
   } cv_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] value;
   } cv_rsp_type;

   typedef enum logic [3:0] {
      CV_IDLE,
      CV_DIV,
      CV_SQRT,
      CV_P2,
      CV_P3,
      CV_SQ,
      CV_PS,
      CV_BUD,
      CV_FIN
   } cv_state_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_QCHK,
      BK_NAW,
      BK_LREL,
      BK_LAW,
      BK_DEC,
      BK_WINIT,
      BK_WLOOP,
      BK_WWAIT,
      BK_WCLAMP,
      BK_WDONE,
      BK_OUT
   } bk_state_type;

endpackage
`default_nettype wire

// ----- hw/rtl/pbrc_req_if.sv -----
// Request channel interface: valid, ready and the fields of one input item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface pbrc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [47:0] time_msec;
   logic [31:0] span_ms;
   logic [31:0] up_quota;
   logic [31:0] down_quota;
   logic        direction;
   logic [1:0]  priority_req;
   logic        applies;
   logic [31:0] byte_count;

   modport source (output valid, kind, time_msec, span_ms, up_quota, down_quota,
                   direction, priority_req, applies, byte_count, input ready);
   modport sink (input valid, kind, time_msec, span_ms, up_quota, down_quota,
                 direction, priority_req, applies, byte_count, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pbrc_rsp_if.sv -----
// Response channel interface: valid, ready and the fields of one result item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface pbrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] allowed_bytes;
   logic [48:0] wake_msec;

   modport source (output valid, allowed_bytes, wake_msec, input ready);
   modport sink (input valid, allowed_bytes, wake_msec, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pbrc_front.sv -----
// Front end: accepts request items, classifies them by kind and queues those of a known kind.
// Depends on pbrc_pkg and pbrc_req_if.
`timescale 1ns / 1ps
`default_nettype none
module pbrc_front import pbrc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   pbrc_req_if.sink req_if,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   item_type   mem_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic       accept, keep, push, pop;
   item_type   item;

   assign req_if.ready = (count_ff != 2'd2);
   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      keep = 1'b1;
      item.op = OP_START;
      case (req_if.kind)
         KIND_START:  item.op = OP_START;
         KIND_QUERY:  item.op = OP_QUERY;
         KIND_CHARGE: item.op = OP_CHARGE;
         default:     keep = 1'b0;
      endcase
      item.time_msec    = req_if.time_msec;
      item.span_ms      = req_if.span_ms;
      item.up_quota     = req_if.up_quota;
      item.down_quota   = req_if.down_quota;
      item.direction    = req_if.direction;
      item.priority_req = req_if.priority_req;
      item.applies      = req_if.applies;
      item.byte_count   = req_if.byte_count;
   end

   assign push = accept && keep;
   assign pop  = q_pop && (count_ff != 2'd0);

   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= item;
      end
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_item  = mem_ff[rd_ff];

endmodule
`default_nettype wire

// ----- hw/rtl/pbrc_curve.sv -----
// Curve unit: value of the release curve at one elapsed time.
// Bit-serial divider and square root, one shared 32x32 multiplier. Uses pbrc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pbrc_curve import pbrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cv_req_type  cv_req,
   input  logic [31:0] budget,
   input  logic [31:0] length,
   input  logic [1:0]  mode,
   output cv_rsp_type  cv_rsp
);

   cv_state_type state_ff, state_in;
   logic [31:0]  drem_ff, drem_in;
   logic [32:0]  srem_ff, srem_in;
   logic [31:0]  src_ff, src_in;
   logic [31:0]  root_ff, root_in;
   logic [31:0]  p_ff, p_in;
   logic [63:0]  prod_ff, prod_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic         which_ff, which_in;
   logic [31:0]  val_ff, val_in;
   logic         done_ff, done_in;

   logic [1:0]  m;
   logic [32:0] r2;
   logic        qb;
   logic [34:0] rs, trial;
   logic [31:0] mul_a, mul_b, hi;
   logic [63:0] mul_p;

   // Curve mode three behaves as balanced.
   assign m  = (mode == MODE_RELAXED || mode == MODE_AGGRESSIVE) ? mode : MODE_BALANCED;
   assign hi = prod_ff[63:32];

   always_comb begin
      mul_a = p_ff;
      mul_b = p_ff;
      case (state_ff)
         CV_P3:   begin mul_a = hi; mul_b = p_ff; end
         CV_SQ:   begin mul_a = hi; mul_b = hi; end
         CV_PS:   begin mul_a = p_ff; mul_b = root_ff; end
         CV_BUD:  begin mul_a = hi; mul_b = budget; end
         default: begin mul_a = p_ff; mul_b = p_ff; end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      drem_in  = drem_ff;
      srem_in  = srem_ff;
      src_in   = src_ff;
      root_in  = root_ff;
      p_in     = p_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      which_in = which_ff;
      val_in   = val_ff;
      done_in  = 1'b0;
      r2       = {drem_ff, 1'b0};
      qb       = (r2 >= {1'b0, length});
      rs       = {srem_ff, src_ff[31:30]};
      trial    = {1'b0, root_ff, 2'b01};
      case (state_ff)
         CV_IDLE: begin
            if (cv_req.start) begin
               which_in = cv_req.which;
               if (cv_req.t >= length) begin
                  val_in  = budget;
                  done_in = 1'b1;
               end else begin
                  drem_in  = cv_req.t;
                  p_in     = 32'd0;
                  cnt_in   = 5'd0;
                  state_in = CV_DIV;
               end
            end
         end
         CV_DIV: begin
            // Restoring division of t * 2^32 by the pulse length, one bit a cycle.
            drem_in = qb ? 32'(r2 - {1'b0, length}) : r2[31:0];
            p_in    = {p_ff[30:0], qb};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               if (m == MODE_RELAXED && !which_ff) begin
                  src_in   = {p_ff[30:0], qb};
                  srem_in  = 33'd0;
                  root_in  = 32'd0;
                  state_in = CV_SQRT;
               end else begin
                  state_in = CV_P2;
               end
            end
         end
         CV_SQRT: begin
            // Two radicand bits a cycle; the low half of the radicand is zero.
            if (rs >= trial) begin
               srem_in = 33'(rs - trial);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               srem_in = rs[32:0];
               root_in = {root_ff[30:0], 1'b0};
            end
            src_in = {src_ff[29:0], 2'b00};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = CV_PS;
            end
         end
         CV_P2: begin
            prod_in = mul_p;
            if (m == MODE_BALANCED) begin
               state_in = which_ff ? CV_SQ : CV_BUD;
            end else begin
               state_in = CV_P3;
            end
         end
         CV_P3: begin
            prod_in  = mul_p;
            state_in = (m == MODE_AGGRESSIVE && which_ff) ? CV_SQ : CV_BUD;
         end
         CV_SQ: begin
            prod_in  = mul_p;
            state_in = CV_BUD;
         end
         CV_PS: begin
            prod_in  = mul_p;
            state_in = CV_BUD;
         end
         CV_BUD: begin
            prod_in  = mul_p;
            state_in = CV_FIN;
         end
         CV_FIN: begin
            val_in   = (hi < budget) ? hi : budget;
            done_in  = 1'b1;
            state_in = CV_IDLE;
         end
         default: state_in = CV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      drem_ff  <= drem_in;
      srem_ff  <= srem_in;
      src_ff   <= src_in;
      root_ff  <= root_in;
      p_ff     <= p_in;
      prod_ff  <= prod_in;
      cnt_ff   <= cnt_in;
      which_ff <= which_in;
      val_ff   <= val_in;
   end

   assign cv_rsp.done  = done_ff;
   assign cv_rsp.value = val_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/pbrc_back.sv -----
// Back end: pulse state, charges, configuration and the admit query sequencer.
// Depends on pbrc_pkg and pbrc_rsp_if; drives the curve unit.
`timescale 1ns / 1ps
`default_nettype none
module pbrc_back import pbrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cv_req_type  cv_req,
   input  cv_rsp_type  cv_rsp,
   output logic [31:0] cv_budget,
   output logic [31:0] cv_length,
   output logic [1:0]  cv_mode,
   pbrc_rsp_if.source  rsp_if
);

   bk_state_type state_ff, state_in;
   logic [47:0]  begin_ff, begin_in;
   logic [31:0]  len_ff, len_in;
   logic [48:0]  end_ff, end_in;
   logic [31:0]  bud_ff [2];
   logic [31:0]  bud_in [2];
   logic [31:0]  nlu_ff [2];
   logic [31:0]  nlu_in [2];
   logic [31:0]  lu_ff [2];
   logic [31:0]  lu_in [2];
   logic [1:0]   mode_ff, mode_in;
   logic [31:0]  inc_ff, inc_in;
   logic [31:0]  quant_ff, quant_in;

   logic         qd_ff, qd_in;
   logic [1:0]   qpri_ff, qpri_in;
   logic         qapp_ff, qapp_in;
   logic [47:0]  qnow_ff, qnow_in;
   logic [31:0]  na_ff, na_in, la_ff, la_in;
   logic         wsel_ff, wsel_in;
   logic [31:0]  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, tgt_ff, tgt_in;
   logic [48:0]  wsum_ff, wsum_in, wv_ff, wv_in, w1_ff, w1_in;
   logic [31:0]  res_alw_ff, res_alw_in;
   logic [48:0]  res_wake_ff, res_wake_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [31:0]  rsp_alw_ff, rsp_alw_in;
   logic [48:0]  rsp_wake_ff, rsp_wake_in;

   logic [31:0] cur_bud, cur_nu, cur_lu, used, el, nr, lr, ninc, linc, grant, wmid;
   logic [48:0] diff, now1, fin, wc;
   logic        rel_full, now_lt_end, waiting;
   logic [32:0] csum;

   // Room left before the next target, capped by the release quantum.
   function automatic logic [31:0] step_inc(input logic [31:0] u, input logic [31:0] b,
                                            input logic [31:0] q);
      logic [31:0] r;
      r = b - u;
      if (u >= b) begin
         return 32'd0;
      end
      return (r > q) ? q : r;
   endfunction

   assign cur_bud    = bud_ff[qd_ff];
   assign cur_nu     = nlu_ff[qd_ff];
   assign cur_lu     = lu_ff[qd_ff];
   assign diff       = {1'b0, qnow_ff} - {1'b0, begin_ff};
   assign now1       = {1'b0, qnow_ff} + 49'd1;
   assign rel_full   = (now1 >= end_ff);
   assign now_lt_end = ({1'b0, qnow_ff} < end_ff);
   assign fin        = end_ff - 49'd1;
   assign used       = wsel_ff ? cur_lu : cur_nu;
   assign wmid       = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_comb begin
      // A query before the pulse start counts as zero elapsed.
      if (qnow_ff < begin_ff) begin
         el = 32'd0;
      end else if (diff[47:0] > {16'd0, len_ff}) begin
         el = len_ff;
      end else begin
         el = diff[31:0];
      end
   end

   always_comb begin
      nr    = (na_ff > cur_nu) ? na_ff - cur_nu : 32'd0;
      lr    = (la_ff > cur_lu) ? la_ff - cur_lu : 32'd0;
      ninc  = step_inc(cur_nu, cur_bud, quant_ff);
      linc  = step_inc(cur_lu, cur_bud, quant_ff);
      grant = (qpri_ff == PRI_NORMAL || nr < lr) ? nr : lr;
      if (qpri_ff == PRI_NORMAL) begin
         waiting = (nr < ninc) && now_lt_end;
      end else begin
         waiting = ((nr < ninc) || (lr < linc)) && now_lt_end;
      end
      wc = (wsum_ff <= {1'b0, qnow_ff}) ? now1 : wsum_ff;
   end

   always_comb begin
      state_in    = state_ff;
      begin_in    = begin_ff;
      len_in      = len_ff;
      end_in      = end_ff;
      bud_in      = bud_ff;
      nlu_in      = nlu_ff;
      lu_in       = lu_ff;
      mode_in     = mode_ff;
      inc_in      = inc_ff;
      quant_in    = quant_ff;
      qd_in       = qd_ff;
      qpri_in     = qpri_ff;
      qapp_in     = qapp_ff;
      qnow_in     = qnow_ff;
      na_in       = na_ff;
      la_in       = la_ff;
      wsel_in     = wsel_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      tgt_in      = tgt_ff;
      wsum_in     = wsum_ff;
      wv_in       = wv_ff;
      w1_in       = w1_ff;
      res_alw_in  = res_alw_ff;
      res_wake_in = res_wake_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_alw_in  = rsp_alw_ff;
      rsp_wake_in = rsp_wake_ff;
      q_pop       = 1'b0;
      cv_req.start = 1'b0;
      cv_req.t     = el;
      cv_req.which = 1'b0;
      csum        = 33'd0;

      if (csr_we) begin
         case (csr_index)
            CSR_CURVE_MODE: mode_in  = csr_wdata[1:0];
            CSR_EXEC_INC:   inc_in   = csr_wdata;
            CSR_RELEASE_Q:  quant_in = csr_wdata;
            default:        ;
         endcase
      end

      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_item.op)
                  OP_START: begin
                     begin_in  = q_item.time_msec;
                     len_in    = q_item.span_ms;
                     end_in    = {1'b0, q_item.time_msec} + {17'd0, q_item.span_ms};
                     bud_in[0] = q_item.up_quota;
                     bud_in[1] = q_item.down_quota;
                     nlu_in[0] = 32'd0;
                     nlu_in[1] = 32'd0;
                     lu_in[0]  = 32'd0;
                     lu_in[1]  = 32'd0;
                  end
                  OP_CHARGE: begin
                     // Low priority advances both counters, high priority neither, the others only the first.
                     if (q_item.byte_count != 32'd0 && q_item.priority_req != PRI_HIGH &&
                         q_item.applies) begin
                        csum = {1'b0, nlu_ff[q_item.direction]} + {1'b0, q_item.byte_count};
                        nlu_in[q_item.direction] =
                           (csum < {1'b0, bud_ff[q_item.direction]}) ? csum[31:0]
                                                                     : bud_ff[q_item.direction];
                        if (q_item.priority_req == PRI_LOW) begin
                           csum = {1'b0, lu_ff[q_item.direction]} + {1'b0, q_item.byte_count};
                           lu_in[q_item.direction] =
                              (csum < {1'b0, bud_ff[q_item.direction]}) ? csum[31:0]
                                                                        : bud_ff[q_item.direction];
                        end
                     end
                  end
                  OP_QUERY: begin
                     qd_in    = q_item.direction;
                     qpri_in  = q_item.priority_req;
                     qapp_in  = q_item.applies;
                     qnow_in  = q_item.time_msec;
                     state_in = BK_QCHK;
                  end
                  default: ;
               endcase
            end
         end
         BK_QCHK: begin
            if (qpri_ff == PRI_HIGH || len_ff == 32'd0 || cur_bud == 32'd0 || !qapp_ff) begin
               res_alw_in  = inc_ff;
               res_wake_in = 49'd0;
               state_in    = BK_OUT;
            end else if (rel_full) begin
               na_in    = cur_bud;
               state_in = BK_LREL;
            end else begin
               cv_req.start = 1'b1;
               state_in     = BK_NAW;
            end
         end
         BK_NAW: begin
            if (cv_rsp.done) begin
               na_in    = cv_rsp.value;
               state_in = BK_LREL;
            end
         end
         BK_LREL: begin
            if (qpri_ff == PRI_NORMAL) begin
               state_in = BK_DEC;
            end else if (rel_full) begin
               la_in    = cur_bud;
               state_in = BK_DEC;
            end else begin
               cv_req.start = 1'b1;
               cv_req.which = 1'b1;
               state_in     = BK_LAW;
            end
         end
         BK_LAW: begin
            if (cv_rsp.done) begin
               la_in    = cv_rsp.value;
               state_in = BK_DEC;
            end
         end
         BK_DEC: begin
            if (waiting) begin
               wsel_in  = 1'b0;
               state_in = BK_WINIT;
            end else begin
               res_alw_in  = (grant < inc_ff) ? grant : inc_ff;
               res_wake_in = 49'd0;
               state_in    = BK_OUT;
            end
         end
         BK_WINIT: begin
            if (used >= cur_bud) begin
               wv_in    = 49'd0;
               state_in = BK_WDONE;
            end else begin
               tgt_in   = used + step_inc(used, cur_bud, quant_ff);
               lo_in    = 32'd0;
               hi_in    = len_ff;
               state_in = BK_WLOOP;
            end
         end
         BK_WLOOP: begin
            // Bisection for the earliest elapsed time whose curve reaches the target.
            if (lo_ff < hi_ff) begin
               mid_in       = wmid;
               cv_req.start = 1'b1;
               cv_req.t     = wmid;
               cv_req.which = wsel_ff;
               state_in     = BK_WWAIT;
            end else begin
               wsum_in  = {1'b0, begin_ff} + {17'd0, lo_ff};
               state_in = BK_WCLAMP;
            end
         end
         BK_WWAIT: begin
            cv_req.t = mid_ff;
            if (cv_rsp.done) begin
               if (cv_rsp.value >= tgt_ff) begin
                  hi_in = mid_ff;
               end else begin
                  lo_in = mid_ff + 32'd1;
               end
               state_in = BK_WLOOP;
            end
         end
         BK_WCLAMP: begin
            wv_in    = (wc < fin) ? wc : fin;
            state_in = BK_WDONE;
         end
         BK_WDONE: begin
            res_alw_in = 32'd0;
            if (qpri_ff == PRI_NORMAL) begin
               res_wake_in = wv_ff;
               state_in    = BK_OUT;
            end else if (!wsel_ff) begin
               w1_in    = wv_ff;
               wsel_in  = 1'b1;
               state_in = BK_WINIT;
            end else begin
               res_wake_in = (w1_ff > wv_ff) ? w1_ff : wv_ff;
               state_in    = BK_OUT;
            end
         end
         BK_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_alw_in   = res_alw_ff;
               rsp_wake_in  = res_wake_ff;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         begin_ff     <= 48'd0;
         len_ff       <= 32'd0;
         end_ff       <= 49'd0;
         bud_ff[0]    <= 32'd0;
         bud_ff[1]    <= 32'd0;
         nlu_ff[0]    <= 32'd0;
         nlu_ff[1]    <= 32'd0;
         lu_ff[0]     <= 32'd0;
         lu_ff[1]     <= 32'd0;
         mode_ff      <= MODE_BALANCED;
         inc_ff       <= EXEC_INC_RESET;
         quant_ff     <= RELEASE_Q_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         begin_ff     <= begin_in;
         len_ff       <= len_in;
         end_ff       <= end_in;
         bud_ff       <= bud_in;
         nlu_ff       <= nlu_in;
         lu_ff        <= lu_in;
         mode_ff      <= mode_in;
         inc_ff       <= inc_in;
         quant_ff     <= quant_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qd_ff       <= qd_in;
      qpri_ff     <= qpri_in;
      qapp_ff     <= qapp_in;
      qnow_ff     <= qnow_in;
      na_ff       <= na_in;
      la_ff       <= la_in;
      wsel_ff     <= wsel_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      tgt_ff      <= tgt_in;
      wsum_ff     <= wsum_in;
      wv_ff       <= wv_in;
      w1_ff       <= w1_in;
      res_alw_ff  <= res_alw_in;
      res_wake_ff <= res_wake_in;
      rsp_alw_ff  <= rsp_alw_in;
      rsp_wake_ff <= rsp_wake_in;
   end

   assign cv_budget = cur_bud;
   assign cv_length = len_ff;
   assign cv_mode   = mode_ff;

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.allowed_bytes = rsp_alw_ff;
   assign rsp_if.wake_msec     = rsp_wake_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/paced_bandwidth_release_curve.sv -----
// Start and charge items are applied in the back end's idle state; a full-grant query
// passes the QCHK and OUT states before its result is registered. A curve evaluation
// runs the bit-serial divider and two to four multiplies, and the 1.5 power adds the
// square root; a waiting query bisects with up to 32 curve evaluations per curve.
// Throughput: one item at a time in the back end; a two-entry queue decouples input.
// Reset: synchronous; clears pulse state and counters, loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module paced_bandwidth_release_curve import pbrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pbrc_req_if.sink    req_if,
   pbrc_rsp_if.source  rsp_if,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic        q_valid, q_pop;
   item_type    q_item;
   cv_req_type  cv_req;
   cv_rsp_type  cv_rsp;
   logic [31:0] cv_budget, cv_length;
   logic [1:0]  cv_mode;

   pbrc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   pbrc_curve u_curve (
      .clock  (clock),
      .reset  (reset),
      .cv_req (cv_req),
      .budget (cv_budget),
      .length (cv_length),
      .mode   (cv_mode),
      .cv_rsp (cv_rsp)
   );

   pbrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cv_req    (cv_req),
      .cv_rsp    (cv_rsp),
      .cv_budget (cv_budget),
      .cv_length (cv_length),
      .cv_mode   (cv_mode),
      .rsp_if    (rsp_if)
   );

endmodule
`default_nettype wire

// ----- dv/paced_bandwidth_release_curve_tb.sv -----
// Self-checking testbench for the paced bandwidth release curve block.
// Depends on pbrc_pkg, pbrc_req_if, pbrc_rsp_if and the block's top level.
`timescale 1ns / 1ps
module paced_bandwidth_release_curve_tb import pbrc_pkg::*; ();

   localparam logic [1:0] ENT_ITEM  = 2'd0;
   localparam logic [1:0] ENT_CFG   = 2'd1;
   localparam logic [1:0] ENT_PAUSE = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [1:0] PRI_ALT_LOW = 2'd3;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [63:0] M32 = 64'hFFFF_FFFF;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic [1:0]  tag;
      item_type    it;
      logic [1:0]  idx;
      logic [31:0] val;
   } entry_type;

   typedef struct {
      logic [31:0] allowed;
      logic [48:0] wake;
   } grant_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   pbrc_req_if req_if();
   pbrc_rsp_if rsp_if();

   paced_bandwidth_release_curve uut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   entry_type pending[$];
   grant_type grants_due[$];
   int        fails;
   logic      req_fire;
   int        gap_left, burst_left, settle;
   int unsigned cyc;

   // Shadow of the block's registers and pulse state.
   logic [1:0]  sh_mode;
   logic [63:0] sh_inc, sh_quantum;
   logic [63:0] sh_begin, sh_len, sh_end;
   logic [63:0] sh_budget[2], sh_nl_used[2], sh_lo_used[2];

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
      return ((a & M32) * (b & M32)) >> 32;
   endfunction

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] r, bt;
      r = 0;
      bt = 64'h1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
         if (v >= r + bt) begin
            v = v - (r + bt);
            r = (r >> 1) + bt;
         end else begin
            r = r >> 1;
         end
         bt = bt >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] curve_power(input logic [63:0] p, input bit second);
      logic [63:0] p2, p3;
      if (p > M32) p = M32;
      p2 = qmul(p, p);
      p3 = qmul(p2, p);
      if (sh_mode == MODE_RELAXED) return second ? p3 : qmul(p, root64(p << 32));
      if (sh_mode == MODE_AGGRESSIVE) return second ? qmul(p3, p3) : p3;
      return second ? qmul(p2, p2) : p2;
   endfunction

   function automatic logic [63:0] curve_bytes(input logic [63:0] t, input logic [63:0] b,
                                               input bit second);
      logic [63:0] p, v;
      if (t >= sh_len) return b;
      p = (t << 32) / sh_len;
      v = (curve_power(p, second) * b) >> 32;
      return v < b ? v : b;
   endfunction

   function automatic logic [63:0] unlocked_bytes(input bit d, input bit second,
                                                  input logic [63:0] now);
      logic [63:0] el;
      if (sh_budget[d] == 0) return 0;
      if (now + 1 >= sh_end || sh_len == 0) return sh_budget[d];
      el = now >= sh_begin ? now - sh_begin : 0;
      if (el > sh_len) el = sh_len;
      return curve_bytes(el, sh_budget[d], second);
   endfunction

   function automatic logic [63:0] step_target(input logic [63:0] used, input logic [63:0] b);
      logic [63:0] inc;
      if (used >= b) return b;
      inc = b - used;
      if (inc > sh_quantum) inc = sh_quantum;
      return used + inc;
   endfunction

   function automatic logic [63:0] step_size(input logic [63:0] used, input logic [63:0] b);
      return step_target(used, b) - (used < b ? used : b);
   endfunction

   function automatic logic [63:0] retry_time(input logic [63:0] used, input logic [63:0] b,
                                              input bit second, input logic [63:0] now);
      logic [63:0] target, lo, hi, mid, w, fin;
      if (b == 0 || used >= b || sh_len == 0) return 0;
      target = step_target(used, b);
      lo = 0;
      hi = sh_len;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (curve_bytes(mid, b, second) >= target) hi = mid;
         else lo = mid + 1;
      end
      w = sh_begin + lo;
      if (w <= now) w = now + 1;
      fin = sh_end > sh_begin ? sh_end - 1 : sh_end;
      return w < fin ? w : fin;
   endfunction

   // Applies one accepted item to the shadow state; queues a grant for queries.
   function automatic void track_item(input item_type it);
      bit d;
      logic [63:0] now, b, s, nu, lu, na, nr, ninc, la, lr, linc, gr, wk, w1, w2;
      bit waiting;
      grant_type g;
      d = it.direction;
      now = {16'd0, it.time_msec};
      b = sh_budget[d];
      if (it.op == OP_START) begin
         sh_begin = now;
         sh_len = {32'd0, it.span_ms};
         sh_end = sh_begin + sh_len;
         sh_budget[0] = {32'd0, it.up_quota};
         sh_budget[1] = {32'd0, it.down_quota};
         sh_nl_used[0] = 0; sh_nl_used[1] = 0;
         sh_lo_used[0] = 0; sh_lo_used[1] = 0;
      end else if (it.op == OP_CHARGE) begin
         if (it.byte_count != 0 && it.priority_req != PRI_HIGH && it.applies) begin
            s = sh_nl_used[d] + {32'd0, it.byte_count};
            sh_nl_used[d] = s < b ? s : b;
            if (it.priority_req == PRI_LOW) begin
               s = sh_lo_used[d] + {32'd0, it.byte_count};
               sh_lo_used[d] = s < b ? s : b;
            end
         end
      end else if (it.op == OP_QUERY) begin
         nu = sh_nl_used[d];
         lu = sh_lo_used[d];
         wk = 0;
         if (it.priority_req == PRI_HIGH || sh_len == 0 || b == 0 || !it.applies) begin
            g.allowed = sh_inc[31:0];
            g.wake = '0;
         end else begin
            na = unlocked_bytes(d, 1'b0, now);
            nr = na > nu ? na - nu : 0;
            ninc = step_size(nu, b);
            if (it.priority_req == PRI_NORMAL) begin
               waiting = nr < ninc && now < sh_end;
               if (waiting) wk = retry_time(nu, b, 1'b0, now);
               gr = nr;
            end else begin
               la = unlocked_bytes(d, 1'b1, now);
               lr = la > lu ? la - lu : 0;
               linc = step_size(lu, b);
               waiting = (nr < ninc || lr < linc) && now < sh_end;
               if (waiting) begin
                  w1 = retry_time(nu, b, 1'b0, now);
                  w2 = retry_time(lu, b, 1'b1, now);
                  wk = w1 > w2 ? w1 : w2;
               end
               gr = nr < lr ? nr : lr;
            end
            if (waiting) begin
               g.allowed = '0;
               g.wake = wk[48:0];
            end else begin
               g.allowed = gr < sh_inc ? gr[31:0] : sh_inc[31:0];
               g.wake = '0;
            end
         end
         grants_due.push_back(g);
      end
   endfunction

   // Driver: items and register writes change at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         csr_we <= 1'b0;
         settle <= 0;
      end else if (req_if.valid && !req_fire) begin
         csr_we <= 1'b0;
      end else if (gap_left > 0) begin
         req_if.valid <= 1'b0;
         csr_we <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending.size() == 0) begin
         req_if.valid <= 1'b0;
         csr_we <= 1'b0;
      end else if (pending[0].tag == ENT_ITEM) begin
         req_if.valid <= 1'b1;
         req_if.kind <= pending[0].it.op;
         req_if.time_msec <= pending[0].it.time_msec;
         req_if.span_ms <= pending[0].it.span_ms;
         req_if.up_quota <= pending[0].it.up_quota;
         req_if.down_quota <= pending[0].it.down_quota;
         req_if.direction <= pending[0].it.direction;
         req_if.priority_req <= pending[0].it.priority_req;
         req_if.applies <= pending[0].it.applies;
         req_if.byte_count <= pending[0].it.byte_count;
         csr_we <= 1'b0;
         void'(pending.pop_front());
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         // Register writes and pauses wait for the block to go quiet.
         req_if.valid <= 1'b0;
         if (grants_due.size() != 0) begin
            settle <= 0;
            csr_we <= 1'b0;
         end else if (settle < SETTLE_CYCLES) begin
            settle <= settle + 1;
            csr_we <= 1'b0;
         end else begin
            settle <= 0;
            if (pending[0].tag == ENT_CFG) begin
               csr_we <= 1'b1;
               csr_index <= pending[0].idx;
               csr_wdata <= pending[0].val;
               case (pending[0].idx)
                  CSR_CURVE_MODE: sh_mode = pending[0].val[1:0];
                  CSR_EXEC_INC: sh_inc = {32'd0, pending[0].val};
                  default: sh_quantum = {32'd0, pending[0].val};
               endcase
            end else begin
               csr_we <= 1'b0;
            end
            void'(pending.pop_front());
         end
      end
      cyc <= cyc + 1;
      if (cyc[9]) rsp_if.ready <= 1'b1;
      else rsp_if.ready <= ($urandom_range(0, 2) != 0);
   end

   // Monitor: accepted items update the shadow, results are checked in order.
   always @(posedge clock) begin
      grant_type g;
      req_fire <= req_if.valid && req_if.ready && !reset;
      if (!reset && req_if.valid && req_if.ready) begin
         track_item('{op: op_type'(req_if.kind), time_msec: req_if.time_msec,
                      span_ms: req_if.span_ms, up_quota: req_if.up_quota,
                      down_quota: req_if.down_quota, direction: req_if.direction,
                      priority_req: req_if.priority_req, applies: req_if.applies,
                      byte_count: req_if.byte_count});
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (grants_due.size() == 0) begin
            $display("%0t: unexpected result allowed=%0d wake=%0d", $time,
                     rsp_if.allowed_bytes, rsp_if.wake_msec);
            fails = fails + 1;
         end else begin
            g = grants_due.pop_front();
            if (rsp_if.allowed_bytes !== g.allowed) begin
               $display("%0t: allowed_bytes expected %0d actual %0d", $time,
                        g.allowed, rsp_if.allowed_bytes);
               fails = fails + 1;
            end
            if (rsp_if.wake_msec !== g.wake) begin
               $display("%0t: wake_msec expected %0d actual %0d", $time,
                        g.wake, rsp_if.wake_msec);
               fails = fails + 1;
            end
         end
      end
   end

   function automatic item_type noise_item();
      item_type it;
      it.op = op_type'($urandom_range(0, 2));
      it.time_msec = {16'($urandom_range(0, 16'hFFFF)), $urandom};
      it.span_ms = $urandom;
      it.up_quota = $urandom;
      it.down_quota = $urandom;
      it.direction = 1'($urandom_range(0, 1));
      it.priority_req = 2'($urandom_range(0, 3));
      it.applies = 1'($urandom_range(0, 1));
      it.byte_count = $urandom;
      return it;
   endfunction

   task automatic add_item(input item_type it);
      entry_type e;
      e.tag = ENT_ITEM; e.it = it; e.idx = '0; e.val = '0;
      pending.push_back(e);
   endtask

   task automatic add_cfg(input logic [1:0] idx, input logic [31:0] val);
      entry_type e;
      e.tag = ENT_CFG; e.it = noise_item(); e.idx = idx; e.val = val;
      pending.push_back(e);
   endtask

   task automatic add_pause();
      entry_type e;
      e.tag = ENT_PAUSE; e.it = noise_item(); e.idx = '0; e.val = '0;
      pending.push_back(e);
   endtask

   task automatic add_start(input logic [47:0] t0, input logic [31:0] dur,
                            input logic [31:0] up, input logic [31:0] down);
      item_type it;
      it = noise_item();
      it.op = OP_START; it.time_msec = t0; it.span_ms = dur;
      it.up_quota = up; it.down_quota = down;
      add_item(it);
   endtask

   task automatic add_query(input logic [47:0] t, input bit d, input logic [1:0] pri,
                            input bit ap);
      item_type it;
      it = noise_item();
      it.op = OP_QUERY; it.time_msec = t; it.direction = d;
      it.priority_req = pri; it.applies = ap;
      add_item(it);
   endtask

   task automatic add_charge(input bit d, input logic [1:0] pri, input bit ap,
                             input logic [31:0] n);
      item_type it;
      it = noise_item();
      it.op = OP_CHARGE; it.direction = d; it.priority_req = pri;
      it.applies = ap; it.byte_count = n;
      add_item(it);
   endtask

   function automatic logic [31:0] pick_budget();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return $urandom;
         2: return 32'hFFFF_FFFF;
         default: return $urandom_range(1, 200000);
      endcase
   endfunction

   task automatic build_directed();
      item_type it;
      add_query(48'd50, 1'b0, PRI_NORMAL, 1'b1);
      add_start(48'd1000, 32'd100, 32'd100000, 32'hFFFF_FFFF);
      add_query(48'd10, 1'b0, PRI_LOW, 1'b1);
      add_query(48'd1050, 1'b0, PRI_NORMAL, 1'b1);
      add_query(48'd1050, 1'b1, PRI_LOW, 1'b1);
      add_query(48'd1050, 1'b1, PRI_ALT_LOW, 1'b1);
      add_query(48'd1050, 1'b0, PRI_HIGH, 1'b1);
      add_query(48'd1050, 1'b0, PRI_LOW, 1'b0);
      add_charge(1'b0, PRI_NORMAL, 1'b1, 32'd0);
      add_charge(1'b0, PRI_HIGH, 1'b1, 32'd5000);
      add_charge(1'b0, PRI_LOW, 1'b0, 32'd5000);
      add_charge(1'b0, PRI_ALT_LOW, 1'b1, 32'd30000);
      add_charge(1'b1, PRI_LOW, 1'b1, 32'hFFFF_FFFF);
      add_query(48'd1080, 1'b0, PRI_LOW, 1'b1);
      add_query(48'd1099, 1'b1, PRI_NORMAL, 1'b1);
      add_query(48'd1200, 1'b0, PRI_LOW, 1'b1);
      it = noise_item();
      it.op = op_type'(KIND_UNUSED);
      add_item(it);
      add_start(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0);
      add_query(48'hFFFF_FFFF_FFFF, 1'b0, PRI_LOW, 1'b1);
      add_query(48'hFFFF_FFFF_FFFF, 1'b1, PRI_NORMAL, 1'b1);
      add_start(48'd0, 32'd0, 32'd500, 32'd500);
      add_query(48'd0, 1'b0, PRI_NORMAL, 1'b1);
   endtask

   task automatic build_phase(input int n);
      int made, k;
      logic [47:0] t0, t;
      logic [31:0] dur;
      int r;
      made = 0;
      while (made < n) begin
         if ($urandom_range(0, 9) == 0) begin
            add_item(noise_item());
            made++;
            continue;
         end
         t0 = ($urandom_range(0, 3) == 0) ? {16'($urandom_range(0, 16'hFFFF)), $urandom}
                                          : 48'($urandom_range(0, 100000));
         r = $urandom_range(0, 99);
         if (r < 3) dur = $urandom;
         else if (r < 10) dur = $urandom_range(0, 2);
         else dur = $urandom_range(3, 2000);
         add_start(t0, dur, pick_budget(), pick_budget());
         made++;
         for (k = 0; k < $urandom_range(4, 16); k++) begin
            t = t0 + 48'($urandom_range(0, dur > 2000 ? 2010 : dur + 4)) - 48'd2;
            if ($urandom_range(0, 2) == 0)
               add_charge(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                          $urandom_range(0, 7) != 0,
                          $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 60000));
            else
               add_query(t, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                         $urandom_range(0, 7) != 0);
            made++;
         end
         if ($urandom_range(0, 15) == 0) add_pause();
      end
   endtask

   initial begin
      fails = 0;
      req_fire = 1'b0;
      gap_left = 0;
      burst_left = 0;
      settle = 0;
      cyc = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_CURVE_MODE;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.kind = KIND_START;
      req_if.time_msec = '0;
      req_if.span_ms = '0;
      req_if.up_quota = '0;
      req_if.down_quota = '0;
      req_if.direction = 1'b0;
      req_if.priority_req = PRI_LOW;
      req_if.applies = 1'b0;
      req_if.byte_count = '0;
      rsp_if.ready = 1'b0;
      sh_mode = MODE_BALANCED;
      sh_inc = {32'd0, EXEC_INC_RESET};
      sh_quantum = {32'd0, RELEASE_Q_RESET};
      sh_begin = 0; sh_len = 0; sh_end = 0;
      sh_budget[0] = 0; sh_budget[1] = 0;
      sh_nl_used[0] = 0; sh_nl_used[1] = 0;
      sh_lo_used[0] = 0; sh_lo_used[1] = 0;

      build_directed();
      add_cfg(CSR_CURVE_MODE, {30'd0, MODE_RELAXED});
      add_cfg(CSR_EXEC_INC, 32'hFFFF_FFFF);
      add_cfg(CSR_RELEASE_Q, 32'd0);
      build_phase(120);
      add_cfg(CSR_CURVE_MODE, {30'd0, MODE_AGGRESSIVE});
      add_cfg(CSR_EXEC_INC, 32'd0);
      add_cfg(CSR_RELEASE_Q, 32'hFFFF_FFFF);
      build_phase(120);
      add_cfg(CSR_CURVE_MODE, {30'd0, MODE_UNUSED});
      add_cfg(CSR_EXEC_INC, 32'd16384);
      add_cfg(CSR_RELEASE_Q, 32'd1);
      build_phase(120);
      for (int ph = 0; ph < 3; ph++) begin
         add_cfg(CSR_CURVE_MODE, $urandom_range(0, 3));
         add_cfg(CSR_EXEC_INC, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 70000));
         add_cfg(CSR_RELEASE_Q, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 70000));
         build_phase(130);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      forever begin
         @(posedge clock);
         if (pending.size() == 0 && !req_if.valid && grants_due.size() == 0) break;
      end
      repeat (300) @(posedge clock);
      if (fails == 0 && grants_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #500_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/pbrc_pkg.sv
hw/rtl/pbrc_req_if.sv
hw/rtl/pbrc_rsp_if.sv
hw/rtl/pbrc_front.sv
hw/rtl/pbrc_curve.sv
hw/rtl/pbrc_back.sv
hw/rtl/paced_bandwidth_release_curve.sv
dv/paced_bandwidth_release_curve_tb.sv
